// ===== hw/rtl/xor_rotate_rle_decoder_assert.svh =====
// Assertion macros for the xor_rotate_rle_decoder checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef XOR_ROTATE_RLE_DECODER_ASSERT_SVH
`define XOR_ROTATE_RLE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define XRRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xrrd assertion failed");

// Next-cycle implication, disabled during reset
`define XRRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xrrd assertion failed");

`endif

// ===== hw/rtl/xrrd_pkg.sv =====
// Package for the XOR/rotate run-length decoder: payload types, register
// indexes and sizing constants. No dependencies.
package xrrd_pkg;

	// Sizing
	localparam int OUT_LANES_DEF = 8;
	localparam int MAX_RESULTS   = 32;
	localparam int RES_CNT_W     = $clog2(MAX_RESULTS);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 8;

	// Register reset values
	localparam logic [7:0] KEY_RESET = 8'h5A;
	localparam logic [2:0] ROT_RESET = 3'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE  = 2'd1;

	// Position inside a triplet
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_COUNT  = 2'd1;
	localparam logic [1:0] PH_SYMBOL = 2'd2;

	typedef struct packed {
		logic [7:0] enc_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic [3:0] out_copies;
		logic       out_last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // input transaction taken this cycle
		logic emit;     // load next result into the output register
	} xrrd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic run_start; // current input completes a triplet with nonzero count
		logic out_free;  // output register can take a result this cycle
		logic emit_last; // result being built ends the run
	} xrrd_stat_t;

endpackage

// ===== hw/rtl/xrrd_ctrl.sv =====
// Controller for the XOR/rotate run-length decoder: idle/emit sequencing.
// Depends on xrrd_pkg.
module xrrd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  xrrd_pkg::xrrd_stat_t stat,
	output xrrd_pkg::xrrd_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	// Input is only taken between runs
	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.accept = in_valid & ~in_stall;
	assign cmd.emit   = (state_q == ST_EMIT) & stat.out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && stat.run_start) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit && stat.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/xrrd_dp.sv =====
// Datapath for the XOR/rotate run-length decoder: config registers, decrypt,
// triplet tracking, run splitting and the output register. Depends on xrrd_pkg.
module xrrd_dp #(
	parameter int OUT_LANES = xrrd_pkg::OUT_LANES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [xrrd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [xrrd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  xrrd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output xrrd_pkg::out_item_t                 out_data,
	input  xrrd_pkg::xrrd_cmd_t                 cmd,
	output xrrd_pkg::xrrd_stat_t                stat
);

	localparam logic [7:0] LANES = 8'(OUT_LANES);
	localparam logic [xrrd_pkg::RES_CNT_W-1:0] CNT_MAX =
		xrrd_pkg::RES_CNT_W'(xrrd_pkg::MAX_RESULTS - 1);

	logic [7:0]  key_q;
	logic [2:0]  rot_q;
	logic [1:0]  phase_q;
	logic [7:0]  held_q;
	logic [7:0]  copies_q;
	logic [7:0]  symbol_q;
	logic [xrrd_pkg::RES_CNT_W-1:0] cnt_q;
	logic        out_valid_q;
	xrrd_pkg::out_item_t out_q;

	logic [15:0] rot_wide;
	logic [7:0]  dec_byte;
	logic [7:0]  chunk;
	logic [7:0]  remain;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= xrrd_pkg::KEY_RESET;
			rot_q <= xrrd_pkg::ROT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == xrrd_pkg::REG_XOR_KEY) key_q <= cfg_data;
			if (cfg_index == xrrd_pkg::REG_ROTATE)  rot_q <= cfg_data[2:0];
		end
	end

	// Decrypt: XOR then rotate right
	assign rot_wide = {in_data.enc_byte ^ key_q, in_data.enc_byte ^ key_q} >> rot_q;
	assign dec_byte = rot_wide[7:0];

	// Split the run into results of at most OUT_LANES copies
	assign chunk  = (copies_q > LANES) ? LANES : copies_q;
	assign remain = copies_q - chunk;

	assign stat.run_start = (phase_q == xrrd_pkg::PH_SYMBOL) && (held_q != 8'd0);
	assign stat.out_free  = ~out_valid_q | ~out_stall;
	assign stat.emit_last = (remain == 8'd0) || (cnt_q == CNT_MAX);

	// Triplet phase, control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xrrd_pkg::PH_SKIP;
		end else if (cmd.accept) begin
			if (in_data.in_last) begin
				phase_q <= xrrd_pkg::PH_SKIP;
			end else begin
				unique case (phase_q)
					xrrd_pkg::PH_COUNT:  phase_q <= xrrd_pkg::PH_SYMBOL;
					xrrd_pkg::PH_SYMBOL: phase_q <= xrrd_pkg::PH_SKIP;
					default:             phase_q <= xrrd_pkg::PH_COUNT;
				endcase
			end
		end
	end

	// Count, symbol and run progress
	always_ff @(posedge clk) begin
		if (cmd.accept && phase_q == xrrd_pkg::PH_COUNT) begin
			held_q <= dec_byte;
		end
		if (cmd.accept && phase_q == xrrd_pkg::PH_SYMBOL) begin
			symbol_q <= dec_byte;
			copies_q <= held_q;
			cnt_q    <= '0;
		end else if (cmd.emit) begin
			copies_q <= remain;
			cnt_q    <= cnt_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_symbol <= symbol_q;
			out_q.out_copies <= chunk[3:0];
			out_q.out_last   <= stat.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/xor_rotate_rle_decoder.sv =====
// XOR/rotate decrypting run-length decoder, usage notes
// Input channel (in_valid/in_stall/in_data): one encrypted byte per transaction,
//   with in_last marking the end of a stream; a partial triplet is then dropped.
// Output channel (out_valid/out_stall/out_data): one result per transaction, the
//   symbol with 1..OUT_LANES copies; out_last marks the final result of a run.
// Config port: cfg_we/cfg_index/cfg_data, index 0 xor_key, index 1 rotate_amount.
// Timing: between runs input runs at one byte per cycle; a symbol byte ending a
//   triplet with count N > 0 holds off input until ceil(N/OUT_LANES) results
//   (capped at 32) are loaded. The byte fills the run registers, the controller
//   enters its emit state, then the output register loads the first result. It
//   releases one result per cycle unless stalled, so run length bounds the rate.
// Receiver stall: results hold in the output register and the run sequencer
//   waits; input stays stalled until the last result of the run is loaded.
// Reset: asynchronous, clears the triplet phase and the output valid and loads
//   xor_key 0x5A, rotate_amount 3. No clearing pass; the block is ready at once.
// Depends on xrrd_pkg, xrrd_ctrl, xrrd_dp.
module xor_rotate_rle_decoder #(
	parameter int OUT_LANES = xrrd_pkg::OUT_LANES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xrrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [xrrd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  xrrd_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output xrrd_pkg::out_item_t             out_data
);

	xrrd_pkg::xrrd_cmd_t  cmd;
	xrrd_pkg::xrrd_stat_t stat;

	// Sequencer
	xrrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	xrrd_dp #(
		.OUT_LANES (OUT_LANES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== hw/rtl/xrrd_checker.sv =====
// Port-level checker for xor_rotate_rle_decoder, bound to the top level.
// Depends on xrrd_pkg and xor_rotate_rle_decoder_assert.svh.
`include "xor_rotate_rle_decoder_assert.svh"

module xrrd_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  xrrd_pkg::out_item_t out_data
);

	// A run in progress keeps the input stalled
	`XRRD_ASSERT_IMP(a_run_blocks_input, out_valid && !out_data.out_last, in_stall)

	// A taken non-last result is followed at once by the next one of the run
	`XRRD_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !out_data.out_last, out_valid && out_data.out_symbol == $past(out_data.out_symbol))

	// While input is held off, an empty output register is refilled at once
	`XRRD_ASSERT_NXT(a_emit_when_empty, in_stall && !out_valid, out_valid)

	// Stalled result holds
	`XRRD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind xor_rotate_rle_decoder xrrd_checker u_xrrd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== bench/xor_rotate_rle_decoder_tb.sv =====
// Testbench for xor_rotate_rle_decoder: sends encrypted byte streams and checks
// every run result against an in-bench decrypt/run-length predictor.
// Depends on xrrd_pkg and the xor_rotate_rle_decoder RTL.
`timescale 1ns / 100ps

module xor_rotate_rle_decoder_tb;

	localparam int LANES      = xrrd_pkg::OUT_LANES_DEF;
	localparam int CYCLE_CAP  = 400000;
	localparam int RAND_ITEMS = 140;
	localparam int DRAIN_WAIT = 4;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [xrrd_pkg::CFG_IDX_W-1:0]  cfg_index = xrrd_pkg::REG_XOR_KEY;
	logic [xrrd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	xrrd_pkg::in_item_t              in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	xrrd_pkg::out_item_t             out_data;

	// Predictor copy of the block's registers and triplet state
	logic [7:0] key_q;
	logic [2:0] rot_q;
	logic [1:0] phase_q;
	logic [7:0] count_q;

	xrrd_pkg::out_item_t run_results_q[$];
	int                  mismatches = 0;
	int                  cycles = 0;
	int                  items_sent = 0;
	bit                  gaps_on = 1'b1;
	bit                  stalls_on = 1'b1;
	int                  stall_left = 0;
	xrrd_pkg::out_item_t want;

	xor_rotate_rle_decoder #(.OUT_LANES(LANES)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("xor_rotate_rle_decoder test failed");
			$finish;
		end
	end

	// Decrypt: XOR with key, then rotate right
	function automatic logic [7:0] decrypt(input logic [7:0] enc);
		logic [15:0] w;
		w = {enc ^ key_q, enc ^ key_q} >> rot_q;
		return w[7:0];
	endfunction

	// Inverse of decrypt: rotate left, then XOR with key
	function automatic logic [7:0] encrypt(input logic [7:0] plain);
		logic [15:0] w;
		w = {plain, plain} << rot_q;
		return w[15:8] ^ key_q;
	endfunction

	// Advance the triplet state for one accepted byte and queue the run it emits
	task automatic decode_accepted(input xrrd_pkg::in_item_t item);
		logic [7:0]          b;
		logic [7:0]          left;
		logic [7:0]          take;
		xrrd_pkg::out_item_t r;
		int                  n;
		b = decrypt(item.enc_byte);
		case (phase_q)
			xrrd_pkg::PH_COUNT: begin
				count_q = b;
				phase_q = xrrd_pkg::PH_SYMBOL;
			end
			xrrd_pkg::PH_SYMBOL: begin
				phase_q = xrrd_pkg::PH_SKIP;
				left = count_q;
				n = 0;
				while (left != 0 && n < xrrd_pkg::MAX_RESULTS) begin
					take = (left > LANES) ? 8'(LANES) : left;
					left = left - take;
					r.out_symbol = b;
					r.out_copies = take[3:0];
					r.out_last   = (left == 0) || (n == xrrd_pkg::MAX_RESULTS - 1);
					run_results_q.push_back(r);
					n++;
				end
			end
			default: phase_q = xrrd_pkg::PH_COUNT;
		endcase
		if (item.in_last)
			phase_q = xrrd_pkg::PH_SKIP;
	endtask

	// One input transaction; valid stays up on return so back-to-back sends need no gap
	task automatic send_byte(input logic [7:0] enc, input logic last);
		int gap;
		xrrd_pkg::in_item_t item;
		item.enc_byte = enc;
		item.in_last  = last;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_accepted(item);
		items_sent++;
	endtask

	task automatic send_plain(input logic [7:0] plain, input logic last);
		send_byte(encrypt(plain), last);
	endtask

	// Full triplet with chosen count and symbol
	task automatic send_run(input logic [7:0] cnt, input logic [7:0] sym, input logic last);
		send_plain(8'($urandom), 1'b0);
		send_plain(cnt, 1'b0);
		send_plain(sym, last);
	endtask

	// Drop valid and wait until every queued result is out
	task automatic settle();
		in_valid <= 1'b0;
		while (run_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write both registers; upper bits of the rotate data are junk the block must ignore
	task automatic write_regs(input logic [7:0] key, input logic [7:0] rot_data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= xrrd_pkg::REG_XOR_KEY;
		cfg_data  <= key;
		@(posedge clk);
		cfg_index <= xrrd_pkg::REG_ROTATE;
		cfg_data  <= rot_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_q = key;
		rot_q = rot_data[2:0];
	endtask

	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'd0;
		else if (r < 70)
			return 8'($urandom_range(1, 24));
		else if (r < 95)
			return 8'($urandom_range(25, 255));
		return 8'd255;
	endfunction

	// Output side: random stall per result, check each transaction in order
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (run_results_q.size() == 0) begin
				$error("unexpected result: out_symbol %0h out_copies %0d out_last %0b",
					out_data.out_symbol, out_data.out_copies, out_data.out_last);
				mismatches++;
			end else begin
				want = run_results_q.pop_front();
				if (out_data.out_symbol !== want.out_symbol) begin
					$error("out_symbol: expected %0h, got %0h", want.out_symbol,
						out_data.out_symbol);
					mismatches++;
				end
				if (out_data.out_copies !== want.out_copies) begin
					$error("out_copies: expected %0d, got %0d", want.out_copies,
						out_data.out_copies);
					mismatches++;
				end
				if (out_data.out_last !== want.out_last) begin
					$error("out_last: expected %0b, got %0b", want.out_last,
						out_data.out_last);
					mismatches++;
				end
			end
			stall_left = stalls_on ? $urandom_range(0, 6) : 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	// Reset register values, lane boundaries, zero count, stream ends
	task automatic test_directed();
		send_run(8'd3, 8'hFF, 1'b0);
		send_run(8'd0, 8'h11, 1'b0);
		send_run(8'd1, 8'h00, 1'b0);
		send_run(8'd8, 8'h80, 1'b0);
		send_run(8'd9, 8'h7F, 1'b0);
		send_run(8'd255, 8'hC3, 1'b0);
		// partial triplet cut by a last byte on the count
		send_plain(8'h22, 1'b0);
		send_plain(8'd5, 1'b1);
		// last on the skip byte
		send_plain(8'h33, 1'b1);
		// last on the symbol byte still emits the run
		send_run(8'd2, 8'h44, 1'b1);
		// raw byte extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// Register extremes, zero rotation, junk in unused rotate bits
	task automatic test_register_settings();
		logic [7:0] keys[4];
		logic [2:0] rots[4];
		logic [7:0] rd;
		keys = '{8'h00, 8'hFF, 8'hA5, 8'h3C};
		rots = '{3'd0, 3'd7, 3'd1, 3'd4};
		for (int i = 0; i < 4; i++) begin
			rd = {5'($urandom), rots[i]};
			write_regs(keys[i], rd);
			send_run(8'($urandom_range(1, 20)), 8'($urandom), 1'b0);
			send_run(8'($urandom_range(1, 20)), 8'($urandom), 1'b1);
		end
	endtask

	// Sender holds off until the output side has drained completely
	task automatic test_drain_pause();
		stalls_on = 1'b1;
		send_run(8'd40, 8'h5C, 1'b0);
		send_run(8'd7, 8'hA3, 1'b0);
		settle();
		send_run(8'd17, 8'h0F, 1'b1);
	endtask

	// Mostly well-formed triplets, with noise bytes and truncated triplets mixed in
	task automatic test_random_stream();
		int start;
		int next_cfg;
		int kind;
		logic [7:0] rd;
		start = items_sent;
		next_cfg = start + 50;
		while (items_sent - start < RAND_ITEMS) begin
			if (items_sent >= next_cfg) begin
				next_cfg = items_sent + 50;
				gaps_on = $urandom_range(0, 2) != 0;
				stalls_on = $urandom_range(0, 2) != 0;
				rd = 8'($urandom);
				write_regs(8'($urandom), rd);
			end
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				send_run(pick_count(), 8'($urandom), $urandom_range(0, 9) == 0);
			end else if (kind < 85) begin
				send_plain(8'($urandom), 1'b0);
				if ($urandom_range(0, 1))
					send_plain(8'($urandom), 1'b0);
				send_plain(8'($urandom), 1'b1);
			end else begin
				send_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end
		end
	endtask

	initial begin
		key_q   = xrrd_pkg::KEY_RESET;
		rot_q   = xrrd_pkg::ROT_RESET;
		phase_q = xrrd_pkg::PH_SKIP;
		count_q = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_settings();
		test_drain_pause();
		test_random_stream();

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("xor_rotate_rle_decoder test passed");
		else
			$display("xor_rotate_rle_decoder test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/xrrd_pkg.sv
hw/rtl/xrrd_ctrl.sv
hw/rtl/xrrd_dp.sv
hw/rtl/xor_rotate_rle_decoder.sv
hw/rtl/xrrd_checker.sv
bench/xor_rotate_rle_decoder_tb.sv
